/* rtl/core/sutimer_pkg.sv */
// Shared types and constants of the striped-unit completion timer.
`default_nettype none

package sutimer_pkg;

  localparam int unsigned MAX_UNITS_DEF  = 16;
  localparam int unsigned BLOCK_BITS_DEF = 9;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned LBA_W   = 48;
  localparam int unsigned LEN_W   = 23;
  localparam int unsigned DLY_W   = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned UNITS_W = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W = 136;

  localparam logic [SHIFT_W-1:0] SHIFT_LOW   = 5'd9;
  localparam logic [SHIFT_W-1:0] SHIFT_HIGH  = 5'd24;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 5'd12;
  localparam logic [UNITS_W-1:0] UNITS_RST   = 5'd16;

  // piece count: one more bit than the widest quotient of length by 2^SHIFT_LOW
  localparam int unsigned CNT_W = LEN_W - 9 + 1;

  // remainder unit: MOD_STEP dividend bits per cycle
  localparam int unsigned MOD_STEP  = 4;
  localparam int unsigned MOD_ITERS = LBA_W / MOD_STEP;
  localparam int unsigned MOD_IT_W  = $clog2(MOD_ITERS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_SHIFT  = 3'd0,
    CFG_UNITS       = 3'd1,
    CFG_READ_SCHED  = 3'd2,
    CFG_READ_MIN    = 3'd3,
    CFG_WRITE_SCHED = 3'd4,
    CFG_WRITE_MIN   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_OTHER = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EXEC,
    ST_FOLD,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } store_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/sutimer_store.sv */
// Per-unit free-time memory with registered read and reset-cleared valid bits.
`default_nettype none

module sutimer_store import sutimer_pkg::*; #(
  parameter int unsigned DEPTH = MAX_UNITS_DEF,
  parameter int unsigned AW    = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire store_cmd_t        cmd_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic [TIME_W-1:0] wdata_i,
  output logic [TIME_W-1:0]      rdata_o
);

  logic [TIME_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [TIME_W-1:0] rd_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

/* rtl/core/striped_unit_completion_timer.sv */
// Top level of the striped-unit completion timer.
`default_nettype none

// One request at a time. A read or write is accepted, passes through the
// 4-bit-per-cycle remainder unit that finds the first unit, takes a read then
// an update of the free-time memory per piece, and finishes with a fold and a
// load of the output register. A flush reads each unit in use; any other type
// goes straight to the fold and load. The memory read-modify-write per piece
// sets the pace. The result sits in an output register, so the next request is taken while it waits.

module striped_unit_completion_timer import sutimer_pkg::*; #(
  parameter int unsigned MAX_UNITS  = MAX_UNITS_DEF,
  parameter int unsigned BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DLY_W-1:0]     cfg_data_i,
  // request stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // start_block[47:0], byte_length[70:48], start_time[134:71], zero pad
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]           s_axis_tuser,
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // target_time[63:0]
  output logic [TIME_W-1:0]         m_axis_tdata,
  // status[0]
  output logic                      m_axis_tuser
);

  localparam int unsigned UW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

  // configuration registers
  logic [SHIFT_W-1:0] unit_shift_q;
  logic [UNITS_W-1:0] units_q;
  logic [DLY_W-1:0]   rd_sched_q, rd_min_q, wr_sched_q, wr_min_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_shift_q <= SHIFT_RST;
      units_q      <= UNITS_RST;
      rd_sched_q   <= '0;
      rd_min_q     <= '0;
      wr_sched_q   <= '0;
      wr_min_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_UNIT_SHIFT:  unit_shift_q <= cfg_data_i[SHIFT_W-1:0];
        CFG_UNITS:       units_q      <= cfg_data_i[UNITS_W-1:0];
        CFG_READ_SCHED:  rd_sched_q   <= cfg_data_i;
        CFG_READ_MIN:    rd_min_q     <= cfg_data_i;
        CFG_WRITE_SCHED: wr_sched_q   <= cfg_data_i;
        CFG_WRITE_MIN:   wr_min_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective settings
  logic [SHIFT_W-1:0] sh_eff, lsh;
  logic [UNITS_W-1:0] units_eff;

  always_comb begin
    if (unit_shift_q < SHIFT_LOW) begin
      sh_eff = SHIFT_LOW;
    end else if (unit_shift_q > SHIFT_HIGH) begin
      sh_eff = SHIFT_HIGH;
    end else begin
      sh_eff = unit_shift_q;
    end
    lsh = (sh_eff >= SHIFT_W'(BLOCK_BITS)) ? sh_eff - SHIFT_W'(BLOCK_BITS) : '0;
    if (units_q == '0) begin
      units_eff = UNITS_W'(1);
    end else if (32'(units_q) > MAX_UNITS) begin
      units_eff = UNITS_W'(MAX_UNITS);
    end else begin
      units_eff = units_q;
    end
  end

  // input fields
  logic [LBA_W-1:0]  in_lba;
  logic [LEN_W-1:0]  in_len;
  logic [TIME_W-1:0] in_start;
  req_type_e         in_type;

  assign in_lba   = s_axis_tdata[LBA_W-1:0];
  assign in_len   = s_axis_tdata[LBA_W+LEN_W-1:LBA_W];
  assign in_start = s_axis_tdata[LBA_W+LEN_W+TIME_W-1:LBA_W+LEN_W];
  assign in_type  = req_type_e'(s_axis_tuser);

  // piece count: ceil(len / 2^sh), at least one
  logic [LEN_W-1:0] len_mask, len_whole;
  logic [CNT_W-1:0] pieces;

  always_comb begin
    len_mask  = (LEN_W'(1) << sh_eff) - LEN_W'(1);
    len_whole = in_len >> sh_eff;
    pieces    = len_whole[CNT_W-1:0] + CNT_W'(|(in_len & len_mask));
    if (in_len == '0) begin
      pieces = CNT_W'(1);
    end
  end

  // datapath state
  state_e              state_q, state_d;
  logic                is_flush_q, status_q;
  logic [TIME_W-1:0]   start_q, latest_q, end_q;
  logic [DLY_W-1:0]    sd_q, md_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [UW-1:0]       unit_q;
  logic [LBA_W-1:0]    modv_q;
  logic [UNITS_W-1:0]  modr_q;
  logic [MOD_IT_W-1:0] iter_q;
  logic [TIME_W-1:0]   out_q;
  logic                out_st_q, out_vld_q;

  logic              accept, out_load;
  logic [TIME_W-1:0] rdata, piece_end, fold_max, base;
  logic [UNITS_W-1:0] modr_nx;
  logic [UW:0]       unit_inc;
  logic [UW-1:0]     unit_nx;
  store_cmd_t        store_cmd;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_LOAD) && (!out_vld_q || m_axis_tready);

  // remainder unit: MOD_STEP restoring steps on the top dividend bits
  always_comb begin
    logic [UNITS_W:0] t;
    modr_nx = modr_q;
    for (int k = 0; k < MOD_STEP; k++) begin
      t = {modr_nx, modv_q[LBA_W-1-k]};
      if (t >= {1'b0, units_eff}) begin
        t = t - {1'b0, units_eff};
      end
      modr_nx = t[UNITS_W-1:0];
    end
  end

  always_comb begin
    fold_max  = (end_q > latest_q) ? end_q : latest_q;
    base      = (rdata > start_q) ? rdata : start_q;
    piece_end = is_flush_q ? rdata : base + TIME_W'(sd_q);
    unit_inc  = {1'b0, unit_q} + (UW+1)'(1);
    unit_nx   = (32'(unit_inc) >= 32'(units_eff)) ? '0 : unit_inc[UW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_type)
            REQ_READ, REQ_WRITE: state_d = ST_MOD;
            REQ_FLUSH:           state_d = ST_READ;
            default:             state_d = ST_FOLD;
          endcase
        end
      end
      ST_MOD:  if (iter_q == MOD_IT_W'(MOD_ITERS - 1)) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = (cnt_q == CNT_W'(1)) ? ST_FOLD : ST_READ;
      ST_FOLD: state_d = ST_LOAD;
      ST_LOAD: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // store control
  always_comb begin
    store_cmd.rd = (state_q == ST_READ);
    store_cmd.wr = (state_q == ST_EXEC) && !is_flush_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          start_q    <= in_start;
          is_flush_q <= (in_type == REQ_FLUSH);
          status_q   <= (in_type == REQ_OTHER);
          latest_q   <= (in_type == REQ_FLUSH) ? '0 : in_start;
          end_q      <= (in_type == REQ_FLUSH) ? '0 : in_start;
          sd_q       <= (in_type == REQ_WRITE) ? wr_sched_q : rd_sched_q;
          md_q       <= (in_type == REQ_WRITE) ? wr_min_q :
                        (in_type == REQ_READ)  ? rd_min_q : '0;
          cnt_q      <= (in_type == REQ_FLUSH) ? CNT_W'(units_eff) : pieces;
          unit_q     <= '0;
          modv_q     <= in_lba >> lsh;
          modr_q     <= '0;
          iter_q     <= '0;
        end
      end
      ST_MOD: begin
        modv_q <= modv_q << MOD_STEP;
        modr_q <= modr_nx;
        iter_q <= iter_q + MOD_IT_W'(1);
        if (iter_q == MOD_IT_W'(MOD_ITERS - 1)) begin
          unit_q <= UW'(modr_nx);
        end
      end
      ST_READ: latest_q <= fold_max;
      ST_EXEC: begin
        end_q  <= piece_end;
        cnt_q  <= cnt_q - CNT_W'(1);
        unit_q <= unit_nx;
      end
      ST_FOLD: latest_q <= fold_max;
      ST_LOAD: begin
        if (out_load) begin
          out_q    <= latest_q + TIME_W'(md_q);
          out_st_q <= status_q;
        end
      end
      default: ;
    endcase
  end

  sutimer_store #(
    .DEPTH (MAX_UNITS),
    .AW    (UW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (store_cmd),
    .addr_i  (unit_q),
    .wdata_i (piece_end),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_st_q;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the striped-unit completion timer: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import sutimer_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNSUP = 1'b1;
  localparam logic [LEN_W-1:0] LEN_MAX = 23'd4194304;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 113;

  typedef struct packed {
    req_type_e        kind;
    logic [LBA_W-1:0] lba;
    logic [LEN_W-1:0] len;
    logic [TIME_W-1:0] t0;
  } request_t;

  typedef struct packed {
    logic [TIME_W-1:0] when;
    logic              unsupported;
  } outcome_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DLY_W-1:0]     reg_val;
    request_t             req;
    bit                   typed;
    outcome_t             want;
  } plan_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_JITTER, SINK_PERIODIC, SINK_CHOKE} sink_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DLY_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TIME_W-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;

  always #6 clk_i = ~clk_i;

  striped_unit_completion_timer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // shadow state of the timer
  logic [TIME_W-1:0]  free_ns [MAX_UNITS_DEF];
  logic [SHIFT_W-1:0] shift_reg = SHIFT_RST;
  logic [UNITS_W-1:0] units_reg = UNITS_RST;
  logic [DLY_W-1:0]   rd_sched = '0;
  logic [DLY_W-1:0]   rd_min = '0;
  logic [DLY_W-1:0]   wr_sched = '0;
  logic [DLY_W-1:0]   wr_min = '0;

  outcome_t    completions_due [$];
  plan_row_t   plan [$];
  int unsigned bad_beats = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic [TIME_W-1:0] now_ns = 64'd1000;

  initial begin
    for (int i = 0; i < MAX_UNITS_DEF; i++) free_ns[i] = '0;
  end

  task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t ns: bad %s: got %h, want %h", $time, what, got, want);
    bad_beats++;
  endtask

  function automatic logic [SHIFT_W-1:0] unit_bits();
    if (shift_reg < SHIFT_LOW) return SHIFT_LOW;
    if (shift_reg > SHIFT_HIGH) return SHIFT_HIGH;
    return shift_reg;
  endfunction

  function automatic logic [63:0] active_units();
    if (units_reg == '0) return 64'd1;
    if (64'(units_reg) > 64'(MAX_UNITS_DEF)) return 64'(MAX_UNITS_DEF);
    return 64'(units_reg);
  endfunction

  function automatic outcome_t forecast_completion(input request_t r);
    outcome_t o;
    logic [SHIFT_W-1:0] sh;
    logic [SHIFT_W-1:0] lsh;
    logic [63:0] units, u, pieces, i, usize, sd, md, fin, latest, slot;
    units = active_units();
    o.unsupported = STATUS_OK;
    case (r.kind)
      REQ_READ, REQ_WRITE: begin
        sh = unit_bits();
        lsh = (sh >= SHIFT_W'(BLOCK_BITS_DEF)) ? sh - SHIFT_W'(BLOCK_BITS_DEF) : '0;
        usize = 64'd1 << sh;
        pieces = (64'(r.len) + usize - 64'd1) >> sh;
        if (pieces == 64'd0) pieces = 64'd1;
        sd = (r.kind == REQ_WRITE) ? 64'(wr_sched) : 64'(rd_sched);
        md = (r.kind == REQ_WRITE) ? 64'(wr_min) : 64'(rd_min);
        u = (64'(r.lba) >> lsh) % units;
        latest = r.t0;
        for (i = 64'd0; i < pieces; i++) begin
          slot = free_ns[u[3:0]];
          fin = ((slot > r.t0) ? slot : r.t0) + sd;
          free_ns[u[3:0]] = fin;
          if (fin > latest) latest = fin;
          u = (u + 64'd1 >= units) ? 64'd0 : u + 64'd1;
        end
        o.when = latest + md;
      end
      REQ_FLUSH: begin
        latest = '0;
        for (i = 64'd0; i < units; i++)
          if (free_ns[i[3:0]] > latest) latest = free_ns[i[3:0]];
        o.when = latest;
      end
      default: begin
        o.when = r.t0;
        o.unsupported = STATUS_UNSUP;
      end
    endcase
    return o;
  endfunction

  function automatic request_t draw_request();
    request_t r;
    int unsigned pick;
    logic [63:0] cap;
    pick = $urandom_range(0, 99);
    r.kind = (pick < 40) ? REQ_READ : (pick < 80) ? REQ_WRITE :
             (pick < 92) ? REQ_FLUSH : REQ_OTHER;
    r.lba = ($urandom_range(0, 3) == 0) ? LBA_W'($urandom_range(0, 255))
                                         : {16'($urandom), 32'($urandom)};
    cap = (64'd6 << unit_bits());
    if (cap > 64'(LEN_MAX)) cap = 64'(LEN_MAX);
    if ($urandom_range(0, 99) < 2) r.len = LEN_W'($urandom_range(0, 32'(LEN_MAX)));
    else r.len = LEN_W'($urandom_range(0, 32'(cap)));
    pick = $urandom_range(0, 19);
    if (pick < 17) begin
      now_ns = now_ns + 64'($urandom_range(0, 4000));
      r.t0 = now_ns;
    end else if (pick < 19) begin
      r.t0 = {32'($urandom), 32'($urandom)};
    end else begin
      r.t0 = '1 - 64'($urandom_range(0, 100000));
    end
    return r;
  endfunction

  function automatic logic [DLY_W-1:0] pick_delay();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return DLY_W'($urandom_range(1, 5000));
      2: return DLY_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic void plan_req(input req_type_e kind, input logic [LBA_W-1:0] lba,
                                   input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] t0,
                                   input bit typed = 1'b0, input logic [TIME_W-1:0] when = '0,
                                   input logic st = 1'b0);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.req = '{kind: kind, lba: lba, len: len, t0: t0};
    row.typed = typed;
    row.want = '{when: when, unsupported: st};
    plan.push_back(row);
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DLY_W-1:0] val);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.req = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  // register writes only once every pending completion has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DLY_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (completions_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_UNIT_SHIFT:  shift_reg = val[SHIFT_W-1:0];
      CFG_UNITS:       units_reg = val[UNITS_W-1:0];
      CFG_READ_SCHED:  rd_sched = val;
      CFG_READ_MIN:    rd_min = val;
      CFG_WRITE_SCHED: wr_sched = val;
      CFG_WRITE_MIN:   wr_min = val;
      default: ;
    endcase
    burst_left = 0;
  endtask

  task automatic send_request(input request_t r, input bit typed, input outcome_t typed_want);
    outcome_t want;
    int unsigned gap;
    cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.t0, r.len, r.lba};
    s_axis_tuser  <= r.kind;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    want = forecast_completion(r);
    if (typed) want = typed_want;
    completions_due.push_back(want);
  endtask

  // result sink with its own stall pattern, checks each beat
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned stall_left = 0;
  int unsigned sink_cycle = 0;

  always @(posedge clk_i) begin : sink
    outcome_t due;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (completions_due.size() == 0) begin
        flag("unexpected result beat", m_axis_tdata, '0);
      end else begin
        due = completions_due.pop_front();
        if (m_axis_tdata !== due.when) flag("target_time", m_axis_tdata, due.when);
        if (m_axis_tuser !== due.unsupported)
          flag("status", 64'(m_axis_tuser), 64'(due.unsupported));
      end
    end
    sink_cycle++;
    if (sink_cycle % 256 == 0) sink_mode = sink_mode_e'($urandom_range(0, 3));
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      case (sink_mode)
        SINK_OPEN:     stall_left = 0;
        SINK_JITTER:   stall_left = $urandom_range(0, 1);
        SINK_PERIODIC: stall_left = 2;
        default:       stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero delays, 4 KiB units, all 16 units
    plan_req(REQ_FLUSH, '0, '0, 64'd77, 1'b1, '0, STATUS_OK);
    plan_req(REQ_OTHER, '1, LEN_MAX, '1, 1'b1, '1, STATUS_UNSUP);
    plan_req(REQ_OTHER, '0, '0, '0, 1'b1, '0, STATUS_UNSUP);
    plan_req(REQ_READ, '0, '0, '0, 1'b1, '0, STATUS_OK);
    plan_req(REQ_READ, 48'd1, 23'd4096, 64'd100, 1'b1, 64'd100, STATUS_OK);
    plan_reg(CFG_READ_SCHED, 32'd1000);
    plan_reg(CFG_READ_MIN, 32'd50);
    plan_reg(CFG_WRITE_SCHED, 32'd2000);
    plan_reg(CFG_WRITE_MIN, 32'd7);
    plan_req(REQ_READ, 48'd8, 23'd8192, 64'd200);
    plan_req(REQ_WRITE, '0, 23'd1, '0);
    plan_req(REQ_WRITE, 48'h0000_0000_0F08, LEN_MAX, 64'd300);
    plan_req(REQ_FLUSH, '0, '0, '0);
    // shift and unit count below range
    plan_reg(CFG_UNIT_SHIFT, 32'd0);
    plan_reg(CFG_UNITS, 32'd0);
    plan_req(REQ_READ, '1, 23'd512, 64'd5000);
    plan_req(REQ_WRITE, 48'h5555_5555_5555, 23'd513, 64'd5000);
    plan_req(REQ_FLUSH, '0, '0, '0);
    // few units, flush skips the idle ones
    plan_reg(CFG_UNITS, 32'd3);
    plan_reg(CFG_UNIT_SHIFT, 32'd10);
    plan_req(REQ_WRITE, 48'hAAAA_AAAA_AAAA, 23'd3000, 64'd9000);
    plan_req(REQ_FLUSH, '0, '0, '0);
    // top of every range, sums wrap
    plan_reg(CFG_UNIT_SHIFT, 32'd31);
    plan_reg(CFG_UNITS, 32'd31);
    plan_reg(CFG_READ_SCHED, '1);
    plan_reg(CFG_READ_MIN, '1);
    plan_reg(CFG_WRITE_SCHED, '1);
    plan_reg(CFG_WRITE_MIN, '1);
    plan_reg(CFG_SPARE_6, 32'h0000_0005);
    plan_reg(CFG_SPARE_7, '1);
    plan_req(REQ_READ, '1, LEN_MAX, 64'hFFFF_FFFF_FFFF_FF00);
    plan_req(REQ_WRITE, 48'h8000_0000_0000, '0, '1);
    plan_req(REQ_FLUSH, '0, '0, '0);
    plan_req(REQ_OTHER, 48'h1234_5678_9ABC, 23'd100, 64'h8000_0000_0000_0001,
             1'b1, 64'h8000_0000_0000_0001, STATUS_UNSUP);
    plan_reg(CFG_UNIT_SHIFT, 32'd24);
    plan_reg(CFG_UNITS, 32'd16);
    plan_req(REQ_READ, '1, LEN_MAX, 64'd20000);
    plan_req(REQ_FLUSH, '0, '0, '0);
    plan_reg(CFG_UNIT_SHIFT, 32'd8);
    plan_reg(CFG_UNITS, 32'd17);
    plan_req(REQ_WRITE, 48'h0000_0000_0003, LEN_MAX, 64'd30000);
    plan_req(REQ_FLUSH, '0, '0, '0);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].reg_idx, plan[k].reg_val);
      else send_request(plan[k].req, plan[k].typed, plan[k].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_UNIT_SHIFT, {($urandom_range(0, 1) != 0) ? 27'($urandom) : 27'd0,
                ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(9, 14))});
      write_reg(CFG_UNITS, {($urandom_range(0, 1) != 0) ? 27'($urandom) : 27'd0,
                ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16))});
      write_reg(CFG_READ_SCHED, pick_delay());
      write_reg(CFG_READ_MIN, pick_delay());
      write_reg(CFG_WRITE_SCHED, pick_delay());
      write_reg(CFG_WRITE_MIN, pick_delay());
      if ($urandom_range(0, 2) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7, DLY_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(draw_request(), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (completions_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (bad_beats == 0 && completions_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
